// File: design/gaussian_spot_renderer_core_assert.svh
// Assertion macros for the spot renderer; clk_i and rst_ni are taken from the enclosing module.
`ifndef GAUSSIAN_SPOT_RENDERER_CORE_ASSERT_SVH
`define GAUSSIAN_SPOT_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gsr: same-cycle check failed");

// Next-cycle implication.
`define GSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gsr: next-cycle check failed");

`endif

// File: design/gsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

  localparam int SPOT_PIXELS = 7;
  localparam int MESH        = 4;
  localparam int MM          = MESH * MESH;
  localparam int HALF        = SPOT_PIXELS / 2;
  localparam int LM          = SPOT_PIXELS * MESH;
  localparam int HALFL       = LM / 2;
  localparam int PIX_W       = (SPOT_PIXELS > 1) ? $clog2(SPOT_PIXELS) : 1;

  localparam int COORD_W = 20;
  localparam int PEAK_W  = 16;
  localparam int SW_W    = 12;
  localparam int CFG_W   = 13;
  localparam int POS_W   = 12;
  localparam int BND_W   = 15;
  localparam logic [CFG_W-1:0] IMAGE_LIMIT = 13'd4096;

  // subsample offsets and squared radius
  localparam int DI_W  = $clog2(LM) + 2;
  localparam int S_RAW = $clog2(2 * HALFL * HALFL + 1);
  localparam int S_W   = (S_RAW > 0) ? S_RAW : 1;

  // reciprocal of MESH^2 * sigma^2, scaled by 2^DIV_M
  localparam int DIV_M = S_W + 31;
  localparam int SH    = DIV_M - 31;
  localparam int K_W   = DIV_M - 10;
  localparam logic [K_W-1:0] K_MAX = {1'b1, {(K_W-1){1'b0}}};
  localparam int D_W   = 2 * SW_W + $clog2(MM + 1);
  localparam int CNT_W = $clog2(DIV_M + 1);

  localparam int EXP_BITS = 20;
  localparam int ACC_W    = 17;
  localparam logic [ACC_W-1:0] EXP_ONE = 17'h10000;
  localparam logic [15:0] EXP_TAB [EXP_BITS] = '{
    16'd65535, 16'd65534, 16'd65532, 16'd65528, 16'd65520, 16'd65504, 16'd65472,
    16'd65408, 16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
    16'd51039, 16'd39750, 16'd24109, 16'd8869,  16'd1200,  16'd22
  };

  localparam int LANE_LAT = EXP_BITS + 3;

  typedef struct packed {
    logic                    valid;
    logic                    empty;
    logic signed [BND_W-1:0] ixbase;
    logic signed [BND_W-1:0] iybase;
    logic [PIX_W-1:0]        pxlo;
    logic [PIX_W-1:0]        pxhi;
    logic [PIX_W-1:0]        pylo;
    logic [PIX_W-1:0]        pyhi;
    logic [PEAK_W-1:0]       peak;
    logic [K_W-1:0]          k;
    logic [D_W-1:0]          d;
  } gsr_spot_t;

  typedef struct packed {
    logic [POS_W-1:0]  ix;
    logic [POS_W-1:0]  iy;
    logic              last;
    logic [PEAK_W-1:0] peak;
  } gsr_meta_t;

endpackage

`default_nettype wire

// File: design/gaussian_spot_renderer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Gaussian spot renderer. A spot is taken when start is high and busy is low;
// busy then stays high while the reciprocal of 16*sigma^2 is worked out bit
// by bit, and this overlaps the previous spot's pixel issue. The issue stage
// sends one in-bounds pixel of the 7x7 footprint per cycle, rows outer. Each
// pixel runs through 16 subsample lanes (exponent, then 20 exp multiply
// stages) and a sum and scale tail before the pixel_valid_o strobe. The
// receiver cannot stall: each beat is shown for one cycle only. A spot with
// no pixel inside the image produces no beat.
`include "gaussian_spot_renderer_core_assert.svh"

module gaussian_spot_renderer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [gsr_pkg::COORD_W-1:0]   spot_x_i,
  input  logic [gsr_pkg::COORD_W-1:0]   spot_y_i,
  input  logic [gsr_pkg::PEAK_W-1:0]    peak_intensity_i,
  input  logic [gsr_pkg::SW_W-1:0]      spot_width_i,
  output logic                          pixel_valid_o,
  output logic [gsr_pkg::POS_W-1:0]     pixel_x_o,
  output logic [gsr_pkg::POS_W-1:0]     pixel_y_o,
  output logic [7:0]                    pixel_increment_o,
  output logic                          last_pixel_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int MESH   = gsr_pkg::MESH;
  localparam int MM     = gsr_pkg::MM;
  localparam int PW     = gsr_pkg::PIX_W;
  localparam int DI_W   = gsr_pkg::DI_W;
  localparam int S_W    = gsr_pkg::S_W;
  localparam int AW     = gsr_pkg::ACC_W;
  localparam int LL     = gsr_pkg::LANE_LAT;
  localparam int META_N = LL + 5;
  localparam int RW     = AW + $clog2(MESH);
  localparam int SUM_W  = RW + $clog2(MESH);
  localparam int P_W    = SUM_W + gsr_pkg::PEAK_W;
  localparam int ZW     = P_W + 8 - 32;
  localparam int RSH    = ZW + $clog2(MM) + 1;
  localparam int RECIP  = (2 ** RSH + MM - 1) / MM;
  localparam logic [ZW-1:0] SAT = ZW'(255);

  // configuration
  logic [gsr_pkg::CFG_W-1:0] width_q, height_q, wlim, hlim;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd256;
      height_q <= 13'd256;
    end else if (wr) begin
      if (paddr[2]) height_q <= pwdata[gsr_pkg::CFG_W-1:0];
      else          width_q  <= pwdata[gsr_pkg::CFG_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'(height_q) : 32'(width_q);
  assign wlim   = (width_q  > gsr_pkg::IMAGE_LIMIT) ? gsr_pkg::IMAGE_LIMIT : width_q;
  assign hlim   = (height_q > gsr_pkg::IMAGE_LIMIT) ? gsr_pkg::IMAGE_LIMIT : height_q;

  // setup
  gsr_pkg::gsr_spot_t spot;
  logic               seq_take;

  gsr_setup u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .spot_x_i (spot_x_i),
    .spot_y_i (spot_y_i),
    .peak_i   (peak_intensity_i),
    .sw_i     (spot_width_i),
    .wlim_i   (wlim),
    .hlim_i   (hlim),
    .take_i   (seq_take),
    .spot_o   (spot)
  );

  // pixel issue
  logic          act_q, act_d;
  logic [PW-1:0] px_q, px_d, py_q, py_d;
  logic          seq_end;
  gsr_pkg::gsr_spot_t cur_q;

  assign seq_end  = act_q && (px_q == cur_q.pxhi) && (py_q == cur_q.pyhi);
  assign seq_take = spot.valid && (!act_q || seq_end);

  always_comb begin
    act_d = act_q;
    px_d  = px_q;
    py_d  = py_q;
    if (seq_take) begin
      act_d = !spot.empty;
      px_d  = spot.pxlo;
      py_d  = spot.pylo;
    end else if (act_q) begin
      if (seq_end) begin
        act_d = 1'b0;
      end else if (px_q == cur_q.pxhi) begin
        px_d = cur_q.pxlo;
        py_d = py_q + 1'b1;
      end else begin
        px_d = px_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      px_q  <= '0;
      py_q  <= '0;
    end else begin
      act_q <= act_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take) cur_q <= spot;
  end

  logic signed [gsr_pkg::BND_W-1:0] ix_full, iy_full;
  gsr_pkg::gsr_meta_t               issue_meta;

  always_comb begin
    ix_full         = cur_q.ixbase + gsr_pkg::BND_W'(px_q);
    iy_full         = cur_q.iybase + gsr_pkg::BND_W'(py_q);
    issue_meta.ix   = ix_full[gsr_pkg::POS_W-1:0];
    issue_meta.iy   = iy_full[gsr_pkg::POS_W-1:0];
    issue_meta.last = seq_end;
    issue_meta.peak = cur_q.peak;
  end

  // squared subsample offsets, column part and row part
  logic signed [DI_W-1:0]   dix [MESH];
  logic signed [DI_W-1:0]   diy [MESH];
  logic signed [2*DI_W-1:0] sqx [MESH];
  logic signed [2*DI_W-1:0] sqy [MESH];
  logic [S_W-1:0]           s_q [MM];
  logic [gsr_pkg::K_W-1:0]  k1_q;
  logic [gsr_pkg::D_W-1:0]  d1_q;
  logic [AW-1:0]            lane_val [MM];

  for (genvar a = 0; a < MESH; a++) begin : g_off
    assign dix[a] = $signed(DI_W'(px_q) * DI_W'(MESH) + DI_W'(a)) -
                    $signed(DI_W'(gsr_pkg::HALFL));
    assign diy[a] = $signed(DI_W'(py_q) * DI_W'(MESH) + DI_W'(a)) -
                    $signed(DI_W'(gsr_pkg::HALFL));
    assign sqx[a] = dix[a] * dix[a];
    assign sqy[a] = diy[a] * diy[a];
  end

  for (genvar l = 0; l < MM; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      s_q[l] <= S_W'(sqy[l / MESH]) + S_W'(sqx[l % MESH]);
    end
    gsr_lane u_lane (
      .clk_i   (clk_i),
      .s_i     (s_q[l]),
      .k_i     (k1_q),
      .d_i     (d1_q),
      .value_o (lane_val[l])
    );
  end

  always_ff @(posedge clk_i) begin
    k1_q <= cur_q.k;
    d1_q <= cur_q.d;
  end

  // beat tracking alongside the lanes
  logic [META_N-1:0]  v_q;
  gsr_pkg::gsr_meta_t meta_q [META_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[META_N-2:0], act_q};
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= issue_meta;
    for (int i = 1; i < META_N; i++) meta_q[i] <= meta_q[i-1];
  end

  // sum and scale
  logic [RW-1:0]    row_c [MESH];
  logic [RW-1:0]    row_q [MESH];
  logic [SUM_W-1:0] tot_c, tot_q;
  logic [P_W-1:0]   prod_q;
  logic [P_W+7:0]   y_c;
  logic [ZW-1:0]    z_q;
  logic [ZW+RSH:0]  qm;
  logic [ZW-1:0]    qv;

  always_comb begin
    for (int b = 0; b < MESH; b++) begin
      row_c[b] = '0;
      for (int a = 0; a < MESH; a++) row_c[b] = row_c[b] + RW'(lane_val[b*MESH+a]);
    end
    tot_c = '0;
    for (int b = 0; b < MESH; b++) tot_c = tot_c + SUM_W'(row_q[b]);
  end

  assign y_c = (P_W+8)'(prod_q) * (P_W+8)'(255);
  assign qm  = (ZW+RSH+1)'(z_q) * (ZW+RSH+1)'(RECIP);
  assign qv  = qm[ZW+RSH-1:RSH];

  always_ff @(posedge clk_i) begin
    row_q  <= row_c;
    tot_q  <= tot_c;
    prod_q <= P_W'(tot_q) * P_W'(meta_q[LL+2].peak);
    z_q    <= y_c[P_W+7:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_o <= 1'b0;
      last_pixel_o  <= 1'b0;
    end else begin
      pixel_valid_o <= v_q[META_N-1];
      last_pixel_o  <= v_q[META_N-1] && meta_q[META_N-1].last;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_o         <= meta_q[META_N-1].ix;
    pixel_y_o         <= meta_q[META_N-1].iy;
    pixel_increment_o <= (qv > SAT) ? 8'd255 : qv[7:0];
  end

  `GSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GSR_ASSERT_NEXT(a_seq_hold, act_q && !seq_end, act_q)
  `GSR_ASSERT_NEXT(a_take_frees_setup, seq_take, !spot.valid)
  `GSR_ASSERT_NOW(a_last_strobe, last_pixel_o, pixel_valid_o)

endmodule

`default_nettype wire

// File: design/gsr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One subsample: exponent by reciprocal with one correction step, then the
// bitwise exp product, one table factor per stage.
module gsr_lane (
  input  logic                        clk_i,
  input  logic [gsr_pkg::S_W-1:0]     s_i,
  input  logic [gsr_pkg::K_W-1:0]     k_i,
  input  logic [gsr_pkg::D_W-1:0]     d_i,
  output logic [gsr_pkg::ACC_W-1:0]   value_o
);

  localparam int P1_W = gsr_pkg::S_W + gsr_pkg::K_W;
  localparam int EB   = gsr_pkg::EXP_BITS;
  localparam int PR_W = EB + gsr_pkg::D_W;
  localparam int CW   = ((gsr_pkg::DIV_M > PR_W) ? gsr_pkg::DIV_M : PR_W) + 1;
  localparam int AW   = gsr_pkg::ACC_W;

  logic [P1_W-1:0]         prod1;
  logic [EB-1:0]           q1_q, q2_q;
  logic                    zf1_q, zf2_q;
  logic [gsr_pkg::S_W-1:0] s1_q, s2_q;
  logic [gsr_pkg::D_W-1:0] d1_q, d2_q;
  logic [PR_W-1:0]         pr2, pr2_q;
  logic [CW-1:0]           x3, diff3;
  logic                    inc3, zero3;
  logic [EB:0]             e3;
  logic [AW-1:0]           acc_q [EB+1];
  logic [EB-1:0]           e_q   [EB];

  assign prod1 = P1_W'(s_i) * P1_W'(k_i);

  always_ff @(posedge clk_i) begin
    q1_q  <= prod1[gsr_pkg::SH+EB-1:gsr_pkg::SH];
    zf1_q <= |prod1[P1_W-1:gsr_pkg::SH+EB];
    s1_q  <= s_i;
    d1_q  <= d_i;
  end

  assign pr2 = PR_W'(q1_q) * PR_W'(d1_q);

  always_ff @(posedge clk_i) begin
    pr2_q <= pr2;
    q2_q  <= q1_q;
    zf2_q <= zf1_q;
    s2_q  <= s1_q;
    d2_q  <= d1_q;
  end

  // truncated quotient is the estimate or one above it
  always_comb begin
    x3    = CW'(s2_q) << 31;
    diff3 = x3 - CW'(pr2_q);
    inc3  = diff3 >= CW'(d2_q);
    e3    = {1'b0, q2_q} + (EB+1)'(inc3);
    zero3 = zf2_q | e3[EB];
  end

  always_ff @(posedge clk_i) begin
    acc_q[0] <= zero3 ? '0 : gsr_pkg::EXP_ONE;
    e_q[0]   <= e3[EB-1:0];
  end

  for (genvar b = 0; b < EB; b++) begin : g_exp
    logic [AW+15:0] m;
    assign m = (AW+16)'(acc_q[b]) * (AW+16)'(gsr_pkg::EXP_TAB[b]);
    always_ff @(posedge clk_i) begin
      acc_q[b+1] <= e_q[b][b] ? m[AW+15:16] : acc_q[b];
    end
    if (b < EB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        e_q[b+1] <= e_q[b];
      end
    end
  end

  assign value_o = acc_q[EB];

endmodule

`default_nettype wire

// File: design/gsr_setup.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-spot setup: footprint clipping, sigma^2 and a restoring reciprocal.
module gsr_setup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [gsr_pkg::COORD_W-1:0]   spot_x_i,
  input  logic [gsr_pkg::COORD_W-1:0]   spot_y_i,
  input  logic [gsr_pkg::PEAK_W-1:0]    peak_i,
  input  logic [gsr_pkg::SW_W-1:0]      sw_i,
  input  logic [gsr_pkg::CFG_W-1:0]     wlim_i,
  input  logic [gsr_pkg::CFG_W-1:0]     hlim_i,
  input  logic                          take_i,
  output gsr_pkg::gsr_spot_t            spot_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } gsr_state_e;

  localparam int BW = gsr_pkg::BND_W;
  localparam int PW = gsr_pkg::PIX_W;
  localparam int DW = gsr_pkg::D_W;
  localparam logic signed [BW-1:0] HALF_B = BW'(gsr_pkg::HALF);
  localparam logic signed [BW-1:0] TOP_B  = BW'(gsr_pkg::SPOT_PIXELS - 1);

  gsr_state_e state_q, state_d;
  logic [gsr_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic                    accept;
  logic [gsr_pkg::COORD_W:0] sumx, sumy;
  logic signed [BW-1:0]    x0, y0, lox, hix, loy, hiy;
  logic                    empty_c;

  logic                    empty_q;
  logic signed [BW-1:0]    ixb_q, iyb_q;
  logic [PW-1:0]           pxlo_q, pxhi_q, pylo_q, pyhi_q;
  logic [gsr_pkg::PEAK_W-1:0] peak_q;
  logic [gsr_pkg::SW_W-1:0]   sw_q;
  logic [DW-1:0]           d_q;
  logic [DW-1:0]           rem_q;
  logic [DW:0]             rem_n;
  logic                    ge;
  logic [gsr_pkg::DIV_M:0] quo_q;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    sumx    = {1'b0, spot_x_i} + (gsr_pkg::COORD_W+1)'(128);
    sumy    = {1'b0, spot_y_i} + (gsr_pkg::COORD_W+1)'(128);
    x0      = $signed(BW'(sumx[gsr_pkg::COORD_W:8]));
    y0      = $signed(BW'(sumy[gsr_pkg::COORD_W:8]));
    lox     = HALF_B - x0;
    loy     = HALF_B - y0;
    hix     = $signed(BW'(wlim_i)) - BW'(1) + HALF_B - x0;
    hiy     = $signed(BW'(hlim_i)) - BW'(1) + HALF_B - y0;
    empty_c = (hix < 0) || (lox > TOP_B) || (lox > hix) ||
              (hiy < 0) || (loy > TOP_B) || (loy > hiy);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_MUL;
      ST_MUL: begin
        state_d = ST_DIV;
        cnt_d   = gsr_pkg::CNT_W'(gsr_pkg::DIV_M);
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: if (take_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // dividend is a single one at bit DIV_M
  assign rem_n = {rem_q, (cnt_q == gsr_pkg::CNT_W'(gsr_pkg::DIV_M))};
  assign ge    = rem_n >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      empty_q <= empty_c;
      ixb_q   <= x0 - HALF_B;
      iyb_q   <= y0 - HALF_B;
      pxlo_q  <= (lox < 0) ? '0 : lox[PW-1:0];
      pylo_q  <= (loy < 0) ? '0 : loy[PW-1:0];
      pxhi_q  <= (hix > TOP_B) ? TOP_B[PW-1:0] : hix[PW-1:0];
      pyhi_q  <= (hiy > TOP_B) ? TOP_B[PW-1:0] : hiy[PW-1:0];
      peak_q  <= peak_i;
      sw_q    <= (sw_i == '0) ? gsr_pkg::SW_W'(1) : sw_i;
    end
    case (state_q)
      ST_MUL: begin
        d_q   <= DW'(sw_q) * DW'(sw_q) * DW'(gsr_pkg::MM);
        rem_q <= '0;
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= ge ? DW'(rem_n - {1'b0, d_q}) : rem_n[DW-1:0];
        quo_q <= {quo_q[gsr_pkg::DIV_M-1:0], ge};
      end
      default: ;
    endcase
  end

  always_comb begin
    spot_o.valid  = (state_q == ST_DONE);
    spot_o.empty  = empty_q;
    spot_o.ixbase = ixb_q;
    spot_o.iybase = iyb_q;
    spot_o.pxlo   = pxlo_q;
    spot_o.pxhi   = pxhi_q;
    spot_o.pylo   = pylo_q;
    spot_o.pyhi   = pyhi_q;
    spot_o.peak   = peak_q;
    spot_o.d      = d_q;
    spot_o.k      = (quo_q > (gsr_pkg::DIV_M+1)'(gsr_pkg::K_MAX)) ?
                    gsr_pkg::K_MAX : quo_q[gsr_pkg::K_W-1:0];
  end

endmodule

`default_nettype wire
